// File: src/puct_child_selector_core_defines.svh
// Assertion macros shared by the PUCT child selector RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PUCT_CHILD_SELECTOR_CORE_DEFINES_SVH
`define PUCT_CHILD_SELECTOR_CORE_DEFINES_SVH

// same-cycle implication
`define PCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pcs_pkg.sv
// Shared constants for the PUCT child selector.
// No dependencies; imported by every module of the block.
package pcs_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int CAND_LIMIT_DEF     = 512;
    localparam int DIGIT_BITS         = 2;

    localparam int GAIN_W    = 16;
    localparam int VISIT_W   = 16;
    localparam int VALUE_W   = 33;
    localparam int PRIOR_W   = 17;
    localparam int INDEX_W   = 9;
    localparam int SCORE_W   = 30;

    localparam int SQRT_IN_W = 32;
    localparam int ROOT_W    = SQRT_IN_W / 2;
    localparam int ROOT_SHIFT = 16;
    localparam int P_W       = 2 * PRIOR_W - FRAC_BITS;
    localparam int U_SHIFT   = 20;
    localparam int CS_W      = GAIN_W + ROOT_W;
    localparam int U_NUM_W   = CS_W + P_W - U_SHIFT;
    localparam int Q_MAG_W   = FRAC_BITS + 2;

    localparam int S_TDATA_W = ((2 * VISIT_W + VALUE_W + 2 * PRIOR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((INDEX_W + SCORE_W + 7) / 8) * 8;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6144);
    localparam logic [Q_MAG_W-1:0] Q_ONE     = Q_MAG_W'(1) << FRAC_BITS;

    localparam logic signed [31:0] SCORE_MAX = 32'sd536870911;
    localparam logic signed [31:0] SCORE_MIN = -32'sd536870912;

endpackage

// File: src/pcs_serial_div.sv
// Restoring unsigned divider, DIGIT_BITS quotient bits per cycle.
// Depends on pcs_pkg.
module pcs_serial_div #(
    parameter int DIVIDEND_W = 33,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);
    import pcs_pkg::*;

    localparam int PAD_W  = ((DIVIDEND_W + DIGIT_BITS - 1) / DIGIT_BITS) * DIGIT_BITS;
    localparam int CYCLES = PAD_W / DIGIT_BITS;
    localparam int CNT_W  = $clog2(CYCLES + 1);

    logic [PAD_W-1:0]     quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    always_comb begin
        logic [DIVISOR_W:0] trial;
        trial    = '0;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (start) begin
            quo_next = PAD_W'(dividend);
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CNT_W'(CYCLES);
        end else if (cnt_reg != '0) begin
            for (int i = 0; i < DIGIT_BITS; i++) begin
                trial    = {rem_next, quo_next[PAD_W-1]};
                quo_next = {quo_next[PAD_W-2:0], 1'b0};
                if (trial >= {1'b0, dsr_reg}) begin
                    trial       = trial - {1'b0, dsr_reg};
                    quo_next[0] = 1'b1;
                end
                rem_next = trial[DIVISOR_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg[DIVIDEND_W-1:0];

endmodule

// File: src/pcs_serial_sqrt.sv
// Digit-by-digit integer square root, DIGIT_BITS root bits per cycle.
// Depends on pcs_pkg.
module pcs_serial_sqrt (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pcs_pkg::SQRT_IN_W-1:0]  radicand,
    output logic                           busy,
    output logic [pcs_pkg::ROOT_W-1:0]     root
);
    import pcs_pkg::*;

    localparam int CYCLES = ROOT_W / DIGIT_BITS;
    localparam int CNT_W  = $clog2(CYCLES + 1);
    localparam int REM_W  = ROOT_W + 2;

    logic [SQRT_IN_W-1:0] val_reg, val_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]    root_reg, root_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    always_comb begin
        logic [REM_W+1:0] acc;
        logic [REM_W+1:0] trial;
        acc       = '0;
        trial     = '0;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(CYCLES);
        end else if (cnt_reg != '0) begin
            for (int i = 0; i < DIGIT_BITS; i++) begin
                acc      = {rem_next, val_next[SQRT_IN_W-1 -: 2]};
                val_next = {val_next[SQRT_IN_W-3:0], 2'b00};
                trial    = (REM_W+2)'({root_next, 2'b01});
                if (acc >= trial) begin
                    acc       = acc - trial;
                    root_next = {root_next[ROOT_W-2:0], 1'b1};
                end else begin
                    root_next = {root_next[ROOT_W-2:0], 1'b0};
                end
                rem_next = acc[REM_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = (cnt_reg != '0);
    assign root = root_reg;

endmodule

// File: src/puct_child_selector_core.sv
// PUCT child selector top level: request handshake, score datapath, running argmax.
// Depends on pcs_pkg, pcs_serial_div, pcs_serial_sqrt and the assertion macro header.
//
// Takes the children of one search node as a stream of requests and, on the request
// marked tlast, returns the position and Q16 score of the child with the highest
// score q + c*p*sqrt(N)/(1+n), the earliest one winning ties. A scored request
// holds s_tready low from its acceptance until it leaves the scoring state, so the
// block takes no new request until it is through with the last: the square root
// of N, the two multiply steps, the divider of the exploration term and the scoring
// state are in series, both units retiring two bits a cycle; the divider for q runs
// beside them. Requests beyond CAND_LIMIT in one node are not scored and go straight
// to the scoring state. The result of a tlast request is registered in the output
// register as that request leaves the scoring state and waits there while the next
// requests are accepted; a tlast request that finds that register still full stalls
// in the scoring state.
`include "puct_child_selector_core_defines.svh"

module puct_child_selector_core #(
    parameter int CAND_LIMIT = pcs_pkg::CAND_LIMIT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pcs_pkg::GAIN_W-1:0]    cfg_wr_data,  // explore_gain, Q4.12
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // parent_visits[15:0], child_visits[31:16], child_wsum[64:32],
    // prior_black[81:65], prior_white[98:82], zero fill
    input  logic [pcs_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,      // is_last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // best_index[8:0], top_score[38:9], zero fill
    output logic [pcs_pkg::M_TDATA_W-1:0] m_tdata
);
    import pcs_pkg::*;

    localparam int POS_W = $clog2(CAND_LIMIT + 1);
    localparam int IDX_W = $clog2(CAND_LIMIT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROOT  = 3'd1;
    localparam logic [2:0] ST_MUL_A = 3'd2;
    localparam logic [2:0] ST_MUL_B = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SCORE = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [SCORE_W-1:0] lead_score_reg, lead_score_next;
    logic [IDX_W-1:0]         lead_index_reg, lead_index_next;
    logic                     has_leader_reg, has_leader_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [INDEX_W-1:0]       m_index_reg, m_index_next;
    logic signed [SCORE_W-1:0] m_score_reg, m_score_next;

    logic [VISIT_W-1:0]       n_reg, n_next;
    logic                     w_neg_reg, w_neg_next;
    logic [PRIOR_W-1:0]       pb_reg, pb_next;
    logic [PRIOR_W-1:0]       pw_reg, pw_next;
    logic                     last_reg, last_next;
    logic                     scored_reg, scored_next;
    logic [P_W-1:0]           p_reg, p_next;
    logic [CS_W-1:0]          cs_reg, cs_next;

    // request fields
    logic [VISIT_W-1:0] s_parent_visits;
    logic [VISIT_W-1:0] s_child_visits;
    logic [VALUE_W-1:0] s_wsum;
    logic [PRIOR_W-1:0] s_prior_black;
    logic [PRIOR_W-1:0] s_prior_white;
    logic [VALUE_W-1:0] s_value_mag;

    assign s_parent_visits = s_tdata[VISIT_W-1:0];
    assign s_child_visits  = s_tdata[2*VISIT_W-1:VISIT_W];
    assign s_wsum          = s_tdata[2*VISIT_W+VALUE_W-1:2*VISIT_W];
    assign s_prior_black   = s_tdata[2*VISIT_W+VALUE_W+PRIOR_W-1:2*VISIT_W+VALUE_W];
    assign s_prior_white   = s_tdata[2*VISIT_W+VALUE_W+2*PRIOR_W-1:2*VISIT_W+VALUE_W+PRIOR_W];
    assign s_value_mag     = s_wsum[VALUE_W-1] ? (~s_wsum + 1'b1) : s_wsum;

    logic accept;
    logic can_score;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign can_score = (pos_reg < POS_W'(CAND_LIMIT));

    // serial arithmetic units
    logic                 q_busy, u_busy, sqrt_busy;
    logic [VALUE_W-1:0]   q_quo;
    logic [U_NUM_W-1:0]   u_quo;
    logic [ROOT_W-1:0]    root;
    logic                 u_start;
    logic [CS_W+P_W-1:0]  cpu_prod;
    logic [VISIT_W:0]     u_divisor;

    assign u_start   = (state_reg == ST_MUL_B);
    assign cpu_prod  = cs_reg * p_reg;
    assign u_divisor = {1'b0, n_reg} + 1'b1;

    pcs_serial_div #(
        .DIVIDEND_W (VALUE_W),
        .DIVISOR_W  (VISIT_W)
    ) u_q_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && can_score),
        .dividend (s_value_mag),
        .divisor  (s_child_visits),
        .busy     (q_busy),
        .quotient (q_quo)
    );

    pcs_serial_div #(
        .DIVIDEND_W (U_NUM_W),
        .DIVISOR_W  (VISIT_W + 1)
    ) u_u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (u_start),
        .dividend (cpu_prod[CS_W+P_W-1:U_SHIFT]),
        .divisor  (u_divisor),
        .busy     (u_busy),
        .quotient (u_quo)
    );

    pcs_serial_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && can_score),
        .radicand ({s_parent_visits, ROOT_SHIFT'(0)}),
        .busy     (sqrt_busy),
        .root     (root)
    );

    // score assembly
    logic [2*PRIOR_W-1:0]      prior_prod;
    logic [Q_MAG_W-1:0]        q_mag;
    logic signed [Q_MAG_W:0]   q_val;
    logic signed [31:0]        score_sum;
    logic signed [SCORE_W-1:0] score_sat;
    logic                      lead_take;
    logic                      out_free;

    assign prior_prod = pb_reg * pw_reg;

    always_comb begin
        q_mag = (q_quo > VALUE_W'(Q_ONE)) ? Q_ONE : q_quo[Q_MAG_W-1:0];
        if (n_reg == '0) begin
            q_val = '0;
        end else if (w_neg_reg) begin
            q_val = -$signed({1'b0, q_mag});
        end else begin
            q_val = $signed({1'b0, q_mag});
        end
        score_sum = 32'(q_val) + $signed(32'(u_quo));
        if (score_sum > SCORE_MAX) begin
            score_sat = SCORE_W'(SCORE_MAX);
        end else if (score_sum < SCORE_MIN) begin
            score_sat = SCORE_W'(SCORE_MIN);
        end else begin
            score_sat = SCORE_W'(score_sum);
        end
    end

    assign lead_take = scored_reg && (!has_leader_reg || (score_sat > lead_score_reg));
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        gain_next       = cfg_wr_en ? cfg_wr_data : gain_reg;
        pos_next        = pos_reg;
        lead_score_next = lead_score_reg;
        lead_index_next = lead_index_reg;
        has_leader_next = has_leader_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_index_next    = m_index_reg;
        m_score_next    = m_score_reg;
        n_next          = n_reg;
        w_neg_next      = w_neg_reg;
        pb_next         = pb_reg;
        pw_next         = pw_reg;
        last_next       = last_reg;
        scored_next     = scored_reg;
        p_next          = p_reg;
        cs_next         = cs_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    n_next      = s_child_visits;
                    w_neg_next  = s_wsum[VALUE_W-1];
                    pb_next     = s_prior_black;
                    pw_next     = s_prior_white;
                    last_next   = s_tlast;
                    scored_next = can_score;
                    state_next  = can_score ? ST_ROOT : ST_SCORE;
                end
            end
            ST_ROOT: begin
                p_next = prior_prod[2*PRIOR_W-1:FRAC_BITS];
                if (!sqrt_busy) begin
                    state_next = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                cs_next    = gain_reg * root;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!u_busy && !q_busy) begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE: begin
                if (!last_reg || out_free) begin
                    state_next = ST_IDLE;
                    if (last_reg) begin
                        m_tvalid_next   = 1'b1;
                        m_index_next    = lead_take ? INDEX_W'(pos_reg[IDX_W-1:0])
                                                    : INDEX_W'(lead_index_reg);
                        m_score_next    = lead_take ? score_sat : lead_score_reg;
                        pos_next        = '0;
                        lead_score_next = '0;
                        lead_index_next = '0;
                        has_leader_next = 1'b0;
                    end else begin
                        if (lead_take) begin
                            lead_score_next = score_sat;
                            lead_index_next = pos_reg[IDX_W-1:0];
                            has_leader_next = 1'b1;
                        end
                        if (scored_reg) begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gain_reg       <= GAIN_RESET;
            pos_reg        <= '0;
            lead_score_reg <= '0;
            lead_index_reg <= '0;
            has_leader_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            gain_reg       <= gain_next;
            pos_reg        <= pos_next;
            lead_score_reg <= lead_score_next;
            lead_index_reg <= lead_index_next;
            has_leader_reg <= has_leader_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_index_reg <= m_index_next;
        m_score_reg <= m_score_next;
        n_reg       <= n_next;
        w_neg_reg   <= w_neg_next;
        pb_reg      <= pb_next;
        pw_reg      <= pw_next;
        last_reg    <= last_next;
        scored_reg  <= scored_next;
        p_reg       <= p_next;
        cs_reg      <= cs_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_score_reg, m_index_reg});

    `PCS_ASSERT_NOW(a_pos_bounded, 1'b1, pos_reg <= POS_W'(CAND_LIMIT),
        "candidate position ran past the limit")
    `PCS_ASSERT_NOW(a_idle_units_quiet, state_reg == ST_IDLE,
        !q_busy && !u_busy && !sqrt_busy, "arithmetic unit busy while idle")
    `PCS_ASSERT_NEXT(a_emit_on_last, state_reg == ST_SCORE && last_reg && out_free,
        m_tvalid_reg, "last request did not produce a result")
    `PCS_ASSERT_NEXT(a_clear_after_emit, state_reg == ST_SCORE && last_reg && out_free,
        pos_reg == '0 && !has_leader_reg, "node state not cleared after result")

endmodule

// File: verif/puct_child_selector_core_tb.sv
// Self-checking testbench for puct_child_selector_core: streams candidate requests,
// predicts the best child of every node and checks each result in order.
// Depends on pcs_pkg and the puct_child_selector_core RTL.
module puct_child_selector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcs_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [VISIT_W-1:0]        parent_visits;
        logic [VISIT_W-1:0]        child_visits;
        logic signed [VALUE_W-1:0] wsum;
        logic [PRIOR_W-1:0]        prior_black;
        logic [PRIOR_W-1:0]        prior_white;
        logic                      last;
    } candidate_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic [SCORE_W-1:0] score;
    } best_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [GAIN_W-1:0]      cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    best_t       pending_best[$];
    int          mismatches = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int          hold_cycles = 0;

    // node tracking
    logic [GAIN_W-1:0] gain_now = GAIN_RESET;
    int                node_pos = 0;
    longint            lead_score = 0;
    int                lead_pos = 0;
    bit                lead_valid = 0;

    puct_child_selector_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic u64_t int_sqrt(u64_t v);
        u64_t r;
        u64_t t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (u64_t'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic longint score_child(candidate_t c);
        longint one;
        longint q;
        longint nv;
        longint score;
        u64_t   p;
        u64_t   root;
        u64_t   u;
        one = longint'(1) << FRAC_BITS;
        nv = longint'(c.child_visits);
        q = 0;
        if (nv != 0) begin
            q = longint'(c.wsum) / nv;
            if (q > one) q = one;
            if (q < -one) q = -one;
        end
        p = (u64_t'(c.prior_black) * u64_t'(c.prior_white)) >> FRAC_BITS;
        root = int_sqrt(u64_t'(c.parent_visits) << 16);
        u = u64_t'(gain_now) * p * root / (u64_t'(nv + 1) << U_SHIFT);
        if (u > 2 * u64_t'(SCORE_MAX)) u = 2 * u64_t'(SCORE_MAX);
        score = q + longint'(u);
        if (score > longint'(SCORE_MAX)) score = longint'(SCORE_MAX);
        if (score < longint'(SCORE_MIN)) score = longint'(SCORE_MIN);
        return score;
    endfunction

    task automatic track_best(input candidate_t c);
        longint s;
        best_t  b;
        if (node_pos < CAND_LIMIT_DEF) begin
            s = score_child(c);
            if (!lead_valid || s > lead_score) begin
                lead_score = s;
                lead_pos = node_pos;
                lead_valid = 1;
            end
            node_pos++;
        end
        if (c.last) begin
            b.index = INDEX_W'(lead_pos);
            b.score = lead_valid ? SCORE_W'(lead_score) : '0;
            pending_best.insert(pending_best.size(), b);
            node_pos = 0;
            lead_score = 0;
            lead_pos = 0;
            lead_valid = 0;
        end
    endtask

    function automatic candidate_t make_candidate(int unsigned big_n, int unsigned n,
                                                  longint w, int unsigned pb,
                                                  int unsigned pw, bit last);
        candidate_t c;
        c.parent_visits = VISIT_W'(big_n);
        c.child_visits  = VISIT_W'(n);
        c.wsum          = VALUE_W'(w);
        c.prior_black   = PRIOR_W'(pb);
        c.prior_white   = PRIOR_W'(pw);
        c.last          = last;
        return c;
    endfunction

    function automatic candidate_t random_candidate();
        candidate_t  c;
        int unsigned pick;
        longint      w;
        pick = $urandom_range(99);
        c.parent_visits = VISIT_W'(pick < 10 ? 0 : pick < 50 ? $urandom_range(1, 200)
                                                             : $urandom_range(0, 65535));
        pick = $urandom_range(99);
        c.child_visits = VISIT_W'(pick < 25 ? 0 : pick < 60 ? $urandom_range(1, 20)
                                                            : $urandom_range(0, 65535));
        if ($urandom_range(3) == 0) begin
            c.wsum = {1'($urandom_range(1)), 32'($urandom())};
        end else begin
            w = (longint'($urandom_range(196608)) - 98304)
                * (c.child_visits == 0 ? 64'sd1 : longint'(c.child_visits));
            c.wsum = VALUE_W'(w);
        end
        pick = $urandom_range(99);
        c.prior_black = PRIOR_W'(pick < 15 ? $urandom_range(0, 131071)
                               : pick < 22 ? 65536 : $urandom_range(0, 65536));
        pick = $urandom_range(99);
        c.prior_white = PRIOR_W'(pick < 15 ? $urandom_range(0, 131071)
                               : pick < 22 ? 65536 : $urandom_range(0, 65536));
        c.last = 1'b0;
        return c;
    endfunction

    task automatic flag_error(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        best_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_best.size() == 0) begin
                flag_error("unexpected result, best_index", -1, m_tdata[8:0]);
            end else begin
                want = pending_best.pop_front();
                if (m_tdata[8:0] !== want.index)
                    flag_error("best_index", want.index, m_tdata[8:0]);
                if (m_tdata[38:9] !== want.score)
                    flag_error("top_score", $signed(want.score), $signed(m_tdata[38:9]));
            end
        end
    end

    task automatic send_request(input candidate_t c);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[15:0]  = c.parent_visits;
        d[31:16] = c.child_visits;
        d[64:32] = c.wsum;
        d[81:65] = c.prior_black;
        d[98:82] = c.prior_white;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= c.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_best(c);
    endtask

    task automatic send_node(input int len);
        candidate_t c;
        candidate_t prev;
        for (int i = 0; i < len; i++) begin
            c = random_candidate();
            if (i > 0 && $urandom_range(9) == 0) c = prev;
            c.last = (i == len - 1);
            prev = c;
            send_request(c);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_best.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gain_now = v;
    endtask

    // runs on the reset value of the gain
    task automatic test_score_extremes();
        send_request(make_candidate(0, 0, 0, 0, 0, 0));
        send_request(make_candidate(65535, 0, 0, 65536, 65536, 0));
        send_request(make_candidate(100, 65535, 64'sd4294901760, 65536, 65536, 0));
        send_request(make_candidate(65535, 0, 0, 65536, 65536, 1));
        send_request(make_candidate(1, 1, -64'sd4294901760, 0, 0, 1));
        send_request(make_candidate(65535, 65535, -1, 131071, 131071, 1));
        settle();
    endtask

    task automatic test_gain_settings();
        write_gain(16'hFFFF);
        send_request(make_candidate(65535, 0, 0, 131071, 131071, 0));
        send_request(make_candidate(65535, 0, 64'sd4294967295, 131071, 131071, 0));
        send_request(make_candidate(16, 3, 200000, 65536, 32768, 1));
        settle();
        write_gain('0);
        send_request(make_candidate(9, 2, -70000, 65536, 65536, 0));
        send_request(make_candidate(9, 2, 70000, 0, 0, 0));
        send_request(make_candidate(9, 2, 70000, 0, 0, 1));
        settle();
    endtask

    task automatic test_ties_and_negatives();
        write_gain(16'd4096);
        send_request(make_candidate(4, 5, -300000, 0, 0, 0));
        send_request(make_candidate(4, 5, -200000, 0, 0, 0));
        send_request(make_candidate(4, 5, -200000, 0, 0, 1));
        send_request(make_candidate(0, 7, -64'sd4294967296, 1, 1, 1));
        settle();
    endtask

    task automatic run_traffic(input int unsigned idle_pct, input int unsigned stall,
                               input logic [GAIN_W-1:0] gain, input int items);
        int sent;
        int len;
        int unsigned pick;
        write_gain(gain);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            len = pick < 5 ? 1 : pick < 75 ? $urandom_range(1, 12) : $urandom_range(13, 40);
            send_node(len);
            sent += len;
        end
        settle();
    endtask

    task automatic test_random_traffic();
        run_traffic(0, 0, 16'($urandom_range(0, 65535)), 360);
        run_traffic(46, 0, GAIN_RESET, 360);
        run_traffic(0, 46, 16'hFFFF, 360);
        run_traffic(22, 22, 16'($urandom_range(1, 8192)), 360);
    endtask

    // beyond CAND_LIMIT_DEF the requests must be ignored until tlast
    task automatic test_candidate_overflow();
        candidate_t c;
        write_gain(GAIN_RESET);
        send_idle_pct = 0;
        stall_pct = 0;
        for (int i = 0; i < CAND_LIMIT_DEF + 8; i++) begin
            c = random_candidate();
            if (i == 300) c = make_candidate(65535, 0, 0, 65536, 65536, 0);
            if (i == CAND_LIMIT_DEF + 3)
                c = make_candidate(65535, 0, 0, 131071, 131071, 0);
            c.last = (i == CAND_LIMIT_DEF + 7);
            send_request(c);
        end
        settle();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 400;
        for (int i = 0; i < 8; i++) send_node(2);
        settle();
        stall_pct = 22;
        send_idle_pct = 22;
        hold_cycles = 300;
        for (int i = 0; i < 6; i++) send_node($urandom_range(1, 3));
        settle();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_score_extremes();
        test_gain_settings();
        test_ties_and_negatives();
        test_random_traffic();
        test_candidate_overflow();
        test_output_backpressure();
        settle();
        if (mismatches == 0 && pending_best.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
